// ===== hw/rtl/fdm_pkg.sv =====
`timescale 1ns / 1ps
package fdm_pkg;

  // stream geometry
  localparam int FLOW_W = 16;
  localparam int MAX_W  = 1024;
  localparam int COL_W  = $clog2(MAX_W);
  localparam int WID_W  = 11;
  localparam int ROW_W  = 16;
  localparam int THR_W  = 18;
  localparam int K_W    = COL_W + 2;

  // smoothness arithmetic
  localparam int MAG_W  = 19;
  localparam int SUM_W  = MAG_W + 1;
  localparam int NTERM  = 11;

  // configuration port
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 18;

  localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH      = 2'd0;
  localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT     = 2'd1;
  localparam logic [CFG_AW-1:0] REG_SMOOTH_THRESHOLD = 2'd2;

  localparam logic [WID_W-1:0] WID_RESET = 11'd1024;
  localparam logic [ROW_W-1:0] HGT_RESET = 16'd1024;
  localparam logic [THR_W-1:0] THR_RESET = 18'd282;

  typedef logic signed [FLOW_W-1:0] flow_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [MAG_W-1:0]         mag_t;

  typedef struct packed {
    flow_t u;
    flow_t v;
  } vec_t;

  // line store word: newest row sample and the one a row older
  typedef struct packed {
    vec_t a;
    vec_t b;
  } pair_t;

  // clamped 3x3 cross around the stencil center
  typedef struct packed {
    vec_t c;
    vec_t l;
    vec_t r;
    vec_t t;
    vec_t b;
  } win_t;

  // per-step control that travels with the word
  typedef struct packed {
    logic             p_on;
    logic             p_real;
    logic             x_lo;
    logic             x_hi;
    logic             y_lo;
    logic             y_hi;
    logic             y_ge2;
    logic             q_on;
    logic             q_l;
    logic             q_r;
    logic             last;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] px;
  } tick_t;

  function automatic sum_t sx(input flow_t x);
    return sum_t'(x);
  endfunction

  function automatic mag_t mag(input sum_t x);
    sum_t a;
    a = (x < 0) ? -x : x;
    return a[MAG_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/fdm_ifs.sv =====
`timescale 1ns / 1ps
interface fdm_pix_if;
  import fdm_pkg::*;
  logic  valid;
  logic  ready;
  logic  op;
  flow_t flow_u;
  flow_t flow_v;
  modport source (output valid, op, flow_u, flow_v, input ready);
  modport sink (input valid, op, flow_u, flow_v, output ready);
endinterface

interface fdm_res_if;
  import fdm_pkg::*;
  logic  valid;
  logic  ready;
  flow_t out_u;
  flow_t out_v;
  logic  bad;
  logic  frame_last;
  modport source (output valid, out_u, out_v, bad, frame_last, input ready);
  modport sink (input valid, out_u, out_v, bad, frame_last, output ready);
endinterface

interface fdm_cfg_if;
  import fdm_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] addr;
  logic [CFG_DW-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// ===== hw/rtl/fdm_ctrl.sv =====
`timescale 1ns / 1ps
module fdm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  fdm_cfg_if.sink              cfg,
  input  logic                 op,
  input  logic                 acc,
  output logic                 tick,
  output fdm_pkg::tick_t       tk,
  output logic [fdm_pkg::THR_W-1:0] thr
);
  import fdm_pkg::*;

  logic [WID_W-1:0] fw, w_new, w, wm1, w_l;
  logic [ROW_W-1:0] fh, h_new, h, hm1, h_l;
  logic             active, in_done, in_done_t, start;
  logic [K_W-1:0]   kcnt, k_t, d1, d2;
  logic [COL_W-1:0] col, col_t, px, px_t, qx, qx_t;
  logic [ROW_W-1:0] rcnt, rcnt_t, py, py_t, qy, qy_t;
  logic             col_end, px_end, qx_end, p_on, q_on, q_last;

  // configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      fw  <= WID_RESET;
      fh  <= HGT_RESET;
      thr <= THR_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        REG_FRAME_WIDTH:      fw  <= cfg.data[WID_W-1:0];
        REG_FRAME_HEIGHT:     fh  <= cfg.data[ROW_W-1:0];
        REG_SMOOTH_THRESHOLD: thr <= cfg.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // frame size taken at frame start
  always_comb begin
    if (fw == '0) w_new = WID_W'(1);
    else if (fw > WID_W'(MAX_W)) w_new = WID_W'(MAX_W);
    else w_new = fw;
    h_new = (fh == '0) ? ROW_W'(1) : fh;
  end

  assign start = !active && !op;
  assign tick  = start || (active && (in_done || !op));

  assign w   = start ? w_new : w_l;
  assign h   = start ? h_new : h_l;
  assign wm1 = w - WID_W'(1);
  assign hm1 = h - ROW_W'(1);
  assign d1  = K_W'(w) + K_W'(1);
  assign d2  = d1 << 1;

  assign k_t       = start ? '0 : kcnt;
  assign col_t     = start ? '0 : col;
  assign rcnt_t    = start ? '0 : rcnt;
  assign in_done_t = start ? 1'b0 : in_done;
  assign px_t      = start ? '0 : px;
  assign py_t      = start ? '0 : py;
  assign qx_t      = start ? '0 : qx;
  assign qy_t      = start ? '0 : qy;

  assign col_end = {1'b0, col_t} == wm1;
  assign px_end  = {1'b0, px_t} == wm1;
  assign qx_end  = {1'b0, qx_t} == wm1;
  assign p_on    = k_t >= d1;
  assign q_on    = k_t >= d2;
  assign q_last  = q_on && qx_end && (qy_t == hm1);

  // step control for the word
  always_comb begin
    tk.p_on   = p_on;
    tk.p_real = py_t < h;
    tk.x_lo   = px_t == '0;
    tk.x_hi   = px_end;
    tk.y_lo   = py_t == '0;
    tk.y_hi   = py_t == hm1;
    tk.y_ge2  = py_t >= ROW_W'(2);
    tk.q_on   = q_on;
    tk.q_l    = qx_t != '0;
    tk.q_r    = !qx_end;
    tk.last   = q_last;
    tk.col    = col_t;
    tk.px     = px_t;
  end

  // frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      in_done <= 1'b0;
      w_l     <= WID_W'(1);
      h_l     <= ROW_W'(1);
      kcnt    <= '0;
      col     <= '0;
      rcnt    <= '0;
      px      <= '0;
      py      <= '0;
      qx      <= '0;
      qy      <= '0;
    end else if (acc && tick) begin
      active  <= !q_last;
      w_l     <= w;
      h_l     <= h;
      in_done <= in_done_t || (col_end && (rcnt_t == hm1));
      kcnt    <= q_on ? k_t : k_t + K_W'(1);
      col     <= col_end ? '0 : col_t + COL_W'(1);
      rcnt    <= col_end ? rcnt_t + ROW_W'(1) : rcnt_t;
      if (p_on) begin
        px <= px_end ? '0 : px_t + COL_W'(1);
        py <= px_end ? py_t + ROW_W'(1) : py_t;
      end else begin
        px <= px_t;
        py <= py_t;
      end
      if (q_on) begin
        qx <= qx_end ? '0 : qx_t + COL_W'(1);
        qy <= qx_end ? qy_t + ROW_W'(1) : qy_t;
      end else begin
        qx <= qx_t;
        qy <= qy_t;
      end
    end
  end

`ifndef SYNTHESIS
  a_kcnt_bound: assert property (@(posedge clk) disable iff (rst)
    active |-> kcnt <= ((K_W'(w_l) + K_W'(1)) << 1))
    else $error("step counter past output start");
  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    active |-> {1'b0, col} < w_l)
    else $error("column counter past frame width");
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (acc && tick && q_last) |=> !active)
    else $error("frame still active after last result");
`endif

endmodule

// ===== hw/rtl/fdm_win.sv =====
`timescale 1ns / 1ps
module fdm_win (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_v,
  input  fdm_pkg::vec_t  in_vec,
  input  fdm_pkg::tick_t in_tk,
  output logic           in_rdy,
  output logic           s2_v,
  output fdm_pkg::win_t  s2_win,
  output fdm_pkg::vec_t  s2_out,
  output fdm_pkg::tick_t s2_tk,
  input  logic           s2_take
);
  import fdm_pkg::*;

  pair_t uvmem [MAX_W];
  pair_t rd, wdata;
  logic  s1_v, s1_adv, s2_adv, acc;
  vec_t  s1_vec;
  tick_t s1_tk;
  vec_t  h1, a1, a2, b1, b2;

  assign s2_adv = s2_v && s2_take;
  assign s1_adv = s1_v && (!s2_v || s2_adv);
  assign in_rdy = !s1_v || s1_adv;
  assign acc    = in_v && in_rdy;
  assign wdata  = {s1_vec, rd.a};

  // stage 1: latch word, read line store
  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (acc) s1_v <= 1'b1;
    else if (s1_adv) s1_v <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_vec <= in_vec;
      s1_tk  <= in_tk;
    end
  end

  // line store read-modify-write, write bypass for a one-column frame
  always_ff @(posedge clk) begin
    if (acc) begin
      if (s1_adv && (s1_tk.col == in_tk.col)) rd <= wdata;
      else rd <= uvmem[in_tk.col];
    end
    if (s1_adv) uvmem[s1_tk.col] <= wdata;
  end

  // stage 2: sample history and clamped cross
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (s1_adv) s2_v <= 1'b1;
    else if (s2_adv) s2_v <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      h1 <= s1_vec;
      a1 <= rd.a;
      a2 <= a1;
      b1 <= rd.b;
      b2 <= b1;
      s2_win.c <= a1;
      s2_win.l <= s1_tk.x_lo ? a1 : a2;
      s2_win.r <= s1_tk.x_hi ? a1 : rd.a;
      s2_win.t <= s1_tk.y_lo ? a1 : b1;
      s2_win.b <= s1_tk.y_hi ? a1 : h1;
      s2_out   <= b2;
      s2_tk    <= s1_tk;
    end
  end

endmodule

// ===== hw/rtl/fdm_rough.sv =====
`timescale 1ns / 1ps
module fdm_rough (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_v,
  input  fdm_pkg::win_t            in_win,
  input  fdm_pkg::vec_t            in_out,
  input  fdm_pkg::tick_t           in_tk,
  output logic                     in_take,
  input  logic [fdm_pkg::THR_W-1:0] thr,
  output logic                     s4_v,
  output logic                     s4_f,
  output fdm_pkg::vec_t            s4_out,
  output fdm_pkg::tick_t           s4_tk,
  input  logic                     s4_take
);
  import fdm_pkg::*;

  mag_t  m_n [NTERM];
  mag_t  m3 [NTERM+1];
  mag_t  mx1 [6];
  mag_t  mx2 [3];
  mag_t  mx3, top;
  logic  s3_v, s3_adv, s4_adv;
  vec_t  s3_out;
  tick_t s3_tk;
  win_t  w;

  assign w       = in_win;
  assign s4_adv  = s4_v && s4_take;
  assign s3_adv  = s3_v && (!s4_v || s4_adv);
  assign in_take = !s3_v || s3_adv;

  // derivative, laplacian and second-difference sum magnitudes
  always_comb begin
    m_n[0]  = mag(sx(w.r.u) - sx(w.c.u));
    m_n[1]  = mag(sx(w.c.u) - sx(w.l.u));
    m_n[2]  = mag(sx(w.b.u) - sx(w.c.u));
    m_n[3]  = mag(sx(w.c.u) - sx(w.t.u));
    m_n[4]  = mag(sx(w.r.v) - sx(w.c.v));
    m_n[5]  = mag(sx(w.c.v) - sx(w.l.v));
    m_n[6]  = mag(sx(w.b.v) - sx(w.c.v));
    m_n[7]  = mag(sx(w.c.v) - sx(w.t.v));
    m_n[8]  = mag((sx(w.c.u) <<< 2) - sx(w.b.u) - sx(w.r.u) - sx(w.t.u) - sx(w.l.u));
    m_n[9]  = mag((sx(w.c.v) <<< 2) - sx(w.b.v) - sx(w.r.v) - sx(w.t.v) - sx(w.l.v));
    m_n[10] = mag(sx(w.l.u) + sx(w.r.u) - (sx(w.c.u) <<< 1)
                  + sx(w.t.v) + sx(w.b.v) - (sx(w.c.v) <<< 1));
  end

  // stage 3: magnitudes
  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (in_v && in_take) s3_v <= 1'b1;
    else if (s3_adv) s3_v <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_v && in_take) begin
      for (int i = 0; i < NTERM; i++) m3[i] <= m_n[i];
      m3[NTERM] <= '0;
      s3_out    <= in_out;
      s3_tk     <= in_tk;
    end
  end

  // max tree and threshold
  always_comb begin
    for (int i = 0; i < 6; i++) mx1[i] = (m3[2*i] > m3[2*i+1]) ? m3[2*i] : m3[2*i+1];
    for (int i = 0; i < 3; i++) mx2[i] = (mx1[2*i] > mx1[2*i+1]) ? mx1[2*i] : mx1[2*i+1];
    mx3 = (mx2[0] > mx2[1]) ? mx2[0] : mx2[1];
    top = (mx3 > mx2[2]) ? mx3 : mx2[2];
  end

  // stage 4: rough flag
  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else if (s3_adv) s4_v <= 1'b1;
    else if (s4_adv) s4_v <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      s4_f   <= s3_tk.p_real && (top > MAG_W'(thr));
      s4_out <= s3_out;
      s4_tk  <= s3_tk;
    end
  end

endmodule

// ===== hw/rtl/fdm_mask.sv =====
`timescale 1ns / 1ps
module fdm_mask (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_v,
  input  logic           in_f,
  input  fdm_pkg::vec_t  in_out,
  input  fdm_pkg::tick_t in_tk,
  output logic           in_take,
  fdm_res_if.source      pix_out
);
  import fdm_pkg::*;

  logic [1:0] fmem [MAX_W];
  logic [1:0] frd, fwd;
  logic       s5_v, s5_adv, s5_f, acc, vor, hist1, hist2, o_v;
  vec_t       s5_out;
  tick_t      s5_tk;

  assign s5_adv  = s5_v && (!o_v || pix_out.ready);
  assign in_take = !s5_v || s5_adv;
  assign acc     = in_v && in_take;
  assign fwd     = {frd[0], s5_f};

  // stage 5: latch flag, read flag rows
  always_ff @(posedge clk) begin
    if (rst) s5_v <= 1'b0;
    else if (acc) s5_v <= 1'b1;
    else if (s5_adv) s5_v <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s5_f   <= in_f;
      s5_out <= in_out;
      s5_tk  <= in_tk;
    end
  end

  // flag row store, bypass when the same column is written back
  always_ff @(posedge clk) begin
    if (acc && in_tk.p_on) begin
      if (s5_adv && s5_tk.p_on && (s5_tk.px == in_tk.px)) frd <= fwd;
      else frd <= fmem[in_tk.px];
    end
    if (s5_adv && s5_tk.p_on) fmem[s5_tk.px] <= fwd;
  end

  // vertical neighbourhood, then horizontal history
  assign vor = s5_f | frd[0] | (s5_tk.y_ge2 & frd[1]);

  always_ff @(posedge clk) begin
    if (s5_adv && s5_tk.p_on) begin
      hist1 <= vor;
      hist2 <= hist1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) o_v <= 1'b0;
    else if (s5_adv) o_v <= s5_tk.q_on;
    else if (pix_out.ready) o_v <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (s5_adv && s5_tk.q_on) begin
      pix_out.out_u      <= s5_out.u;
      pix_out.out_v      <= s5_out.v;
      pix_out.bad        <= hist1 | (s5_tk.q_l & hist2) | (s5_tk.q_r & vor);
      pix_out.frame_last <= s5_tk.last;
    end
  end

  assign pix_out.valid = o_v;

endmodule

// ===== hw/rtl/flow_discontinuity_mask_top.sv =====
// flow discontinuity mask: a result is registered through the window, rough and mask stages
// the emitting step trails its pixel by 2*(W+1) items of the frame, drain items flush the tail
// one item per cycle unless a result waits; line stores do read-modify-write per item
// a waiting result stalls the pipeline, input is taken only while a stage is still free
// reset (rst, synchronous) clears counters, frame state and the pipeline valids
// line stores are not cleared: border clamping keeps unwritten entries out of results
`timescale 1ns / 1ps
module flow_discontinuity_mask_top (
  input  logic      clk,
  input  logic      rst,
  fdm_pix_if.sink   pix_in,
  fdm_res_if.source pix_out,
  fdm_cfg_if.sink   cfg
);
  import fdm_pkg::*;

  logic             tick, acc, win_v, win_rdy, s2_v, r_take, s4_v, s4_f, m_take;
  logic [THR_W-1:0] thr;
  tick_t            tk, s2_tk, s4_tk;
  vec_t             in_vec, s2_out, s4_out;
  win_t             s2_win;

  assign pix_in.ready = win_rdy;
  assign acc          = pix_in.valid && win_rdy;
  assign win_v        = pix_in.valid && tick;
  assign in_vec       = {pix_in.flow_u, pix_in.flow_v};

  // frame sequencing and registers
  fdm_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .op   (pix_in.op),
    .acc  (acc),
    .tick (tick),
    .tk   (tk),
    .thr  (thr)
  );

  // line stores and stencil window
  fdm_win u_win (
    .clk     (clk),
    .rst     (rst),
    .in_v    (win_v),
    .in_vec  (in_vec),
    .in_tk   (tk),
    .in_rdy  (win_rdy),
    .s2_v    (s2_v),
    .s2_win  (s2_win),
    .s2_out  (s2_out),
    .s2_tk   (s2_tk),
    .s2_take (r_take)
  );

  // smoothness measure
  fdm_rough u_rough (
    .clk     (clk),
    .rst     (rst),
    .in_v    (s2_v),
    .in_win  (s2_win),
    .in_out  (s2_out),
    .in_tk   (s2_tk),
    .in_take (r_take),
    .thr     (thr),
    .s4_v    (s4_v),
    .s4_f    (s4_f),
    .s4_out  (s4_out),
    .s4_tk   (s4_tk),
    .s4_take (m_take)
  );

  // neighbourhood marking and result
  fdm_mask u_mask (
    .clk     (clk),
    .rst     (rst),
    .in_v    (s4_v),
    .in_f    (s4_f),
    .in_out  (s4_out),
    .in_tk   (s4_tk),
    .in_take (m_take),
    .pix_out (pix_out)
  );

endmodule
